@@ hdl/alcs_pkg.sv @@
// ----------------------------------------------------------------------------
// alcs_pkg
// Shared types, constants and helpers of the addressable LED chain sender.
// ----------------------------------------------------------------------------
package alcs_pkg;

  localparam int BITS_PER_LED = 24;
  localparam int CHAIN_COUNT  = 2;
  localparam int COLOR_W      = 24;
  localparam int TICK_W       = 8;
  localparam int BIT_POS_W    = $clog2(BITS_PER_LED);
  localparam int BIT_CNT_W    = $clog2(BITS_PER_LED + 1);
  localparam int APB_ADDR_W   = 5;
  localparam int APB_DATA_W   = 32;
  localparam int REG_IDX_W    = 3;

  localparam logic [TICK_W-1:0] ONE_HIGH_RESET  = 8'd16;
  localparam logic [TICK_W-1:0] ONE_LOW_RESET   = 8'd9;
  localparam logic [TICK_W-1:0] ZERO_HIGH_RESET = 8'd8;
  localparam logic [TICK_W-1:0] ZERO_LOW_RESET  = 8'd17;
  localparam logic [TICK_W-1:0] REPEAT_RESET    = 8'd6;

  localparam logic [COLOR_W-1:0] RED_MASK   = 24'hFF0000;
  localparam logic [COLOR_W-1:0] GREEN_MASK = 24'h00FF00;
  localparam logic [COLOR_W-1:0] BLUE_MASK  = 24'h0000FF;

  typedef enum logic [1:0] {
    CMD_SET  = 2'd0,
    CMD_PUSH = 2'd1,
    CMD_TICK = 2'd2,
    CMD_NOP  = 2'd3
  } cmd_t;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_ONE_HIGH  = 3'd0,
    REG_ONE_LOW   = 3'd1,
    REG_ZERO_HIGH = 3'd2,
    REG_ZERO_LOW  = 3'd3,
    REG_REPEAT    = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [TICK_W-1:0] one_high_ticks;
    logic [TICK_W-1:0] one_low_ticks;
    logic [TICK_W-1:0] zero_high_ticks;
    logic [TICK_W-1:0] zero_low_ticks;
    logic [TICK_W-1:0] repeat_count;
  } timing_cfg_t;

  typedef struct packed {
    cmd_t               cmd;
    logic               channel_index;
    logic [COLOR_W-1:0] color_rgb;
  } led_item_t;

  typedef struct packed {
    logic busy_res;
    logic pin_one;
    logic pin_zero;
  } led_result_t;

  // a programmed count of zero behaves as one
  function automatic logic [TICK_W-1:0] at_least_one(input logic [TICK_W-1:0] v);
    return (v == '0) ? TICK_W'(1) : v;
  endfunction

  function automatic logic [COLOR_W-1:0] rgb_to_grb(input logic [COLOR_W-1:0] rgb);
    return ((rgb & GREEN_MASK) << 8) | ((rgb & RED_MASK) >> 8) | (rgb & BLUE_MASK);
  endfunction

endpackage

@@ hdl/alcs_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// alcs_cfg_regs
// APB register file holding the pulse timing and repeat count.
// ----------------------------------------------------------------------------
module alcs_cfg_regs import alcs_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output timing_cfg_t           cfg
);

  logic     wr_en;
  reg_idx_t reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = reg_idx_t'(paddr[APB_ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.one_high_ticks  <= ONE_HIGH_RESET;
      cfg.one_low_ticks   <= ONE_LOW_RESET;
      cfg.zero_high_ticks <= ZERO_HIGH_RESET;
      cfg.zero_low_ticks  <= ZERO_LOW_RESET;
      cfg.repeat_count    <= REPEAT_RESET;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_ONE_HIGH:  cfg.one_high_ticks  <= pwdata[TICK_W-1:0];
        REG_ONE_LOW:   cfg.one_low_ticks   <= pwdata[TICK_W-1:0];
        REG_ZERO_HIGH: cfg.zero_high_ticks <= pwdata[TICK_W-1:0];
        REG_ZERO_LOW:  cfg.zero_low_ticks  <= pwdata[TICK_W-1:0];
        REG_REPEAT:    cfg.repeat_count    <= pwdata[TICK_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_ONE_HIGH:  prdata = APB_DATA_W'(cfg.one_high_ticks);
      REG_ONE_LOW:   prdata = APB_DATA_W'(cfg.one_low_ticks);
      REG_ZERO_HIGH: prdata = APB_DATA_W'(cfg.zero_high_ticks);
      REG_ZERO_LOW:  prdata = APB_DATA_W'(cfg.zero_low_ticks);
      REG_REPEAT:    prdata = APB_DATA_W'(cfg.repeat_count);
      default:       prdata = '0;
    endcase
  end

endmodule

@@ hdl/alcs_engine.sv @@
// ----------------------------------------------------------------------------
// alcs_engine
// Frame state and waveform update; one command applied per enabled cycle.
// ----------------------------------------------------------------------------
module alcs_engine import alcs_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        fire,
  input  led_item_t   item,
  input  timing_cfg_t cfg,
  output led_result_t res
);

  logic [COLOR_W-1:0]   chain_colours [CHAIN_COUNT];
  logic                 sending;
  logic                 current_chain;
  logic [TICK_W-1:0]    repeats_left;
  logic [BIT_POS_W-1:0] bit_position;
  logic                 in_low_phase;
  logic [TICK_W-1:0]    phase_ticks_left;
  logic [COLOR_W-1:0]   shift_word;

  logic                 sending_next;
  logic                 current_chain_next;
  logic [TICK_W-1:0]    repeats_left_next;
  logic [BIT_POS_W-1:0] bit_position_next;
  logic                 in_low_phase_next;
  logic [TICK_W-1:0]    phase_ticks_left_next;
  logic [COLOR_W-1:0]   shift_word_next;
  logic                 colour_we;

  logic [TICK_W-1:0]    ticks_dec;
  logic [TICK_W-1:0]    repeats_dec;
  logic [COLOR_W-1:0]   shifted;
  logic [BIT_CNT_W-1:0] bit_inc;
  logic [COLOR_W-1:0]   cur_colour;
  logic [COLOR_W-1:0]   last_colour;

  function automatic logic [TICK_W-1:0] high_ticks(input logic b, input timing_cfg_t c);
    return at_least_one(b ? c.one_high_ticks : c.zero_high_ticks);
  endfunction

  function automatic logic [TICK_W-1:0] low_ticks(input logic b, input timing_cfg_t c);
    return at_least_one(b ? c.one_low_ticks : c.zero_low_ticks);
  endfunction

  assign ticks_dec   = phase_ticks_left - TICK_W'(1);
  assign repeats_dec = repeats_left - TICK_W'(1);
  assign shifted     = shift_word << 1;
  assign bit_inc     = BIT_CNT_W'(bit_position) + BIT_CNT_W'(1);
  assign cur_colour  = current_chain ? chain_colours[CHAIN_COUNT-1] : chain_colours[0];
  assign last_colour = chain_colours[CHAIN_COUNT-1];

  always_comb begin
    sending_next          = sending;
    current_chain_next    = current_chain;
    repeats_left_next     = repeats_left;
    bit_position_next     = bit_position;
    in_low_phase_next     = in_low_phase;
    phase_ticks_left_next = phase_ticks_left;
    shift_word_next       = shift_word;
    colour_we             = 1'b0;

    unique case (item.cmd)
      CMD_SET: begin
        colour_we = !sending && ((CHAIN_COUNT > 1) || !item.channel_index);
      end
      CMD_PUSH: begin
        if (!sending) begin
          sending_next          = 1'b1;
          current_chain_next    = 1'b0;
          repeats_left_next     = at_least_one(cfg.repeat_count);
          bit_position_next     = '0;
          shift_word_next       = chain_colours[0];
          in_low_phase_next     = 1'b0;
          phase_ticks_left_next = high_ticks(chain_colours[0][COLOR_W-1], cfg);
        end
      end
      CMD_TICK: begin
        if (sending) begin
          if (ticks_dec != '0) begin
            phase_ticks_left_next = ticks_dec;
          end else if (!in_low_phase) begin
            in_low_phase_next     = 1'b1;
            phase_ticks_left_next = low_ticks(shift_word[COLOR_W-1], cfg);
          end else if (bit_inc < BIT_CNT_W'(BITS_PER_LED)) begin
            // next bit of the same LED word
            shift_word_next       = shifted;
            bit_position_next     = bit_inc[BIT_POS_W-1:0];
            in_low_phase_next     = 1'b0;
            phase_ticks_left_next = high_ticks(shifted[COLOR_W-1], cfg);
          end else if (repeats_dec != '0) begin
            // next LED of the same chain
            bit_position_next     = '0;
            repeats_left_next     = repeats_dec;
            shift_word_next       = cur_colour;
            in_low_phase_next     = 1'b0;
            phase_ticks_left_next = high_ticks(cur_colour[COLOR_W-1], cfg);
          end else if (!current_chain && (CHAIN_COUNT > 1)) begin
            // move on to the second chain
            bit_position_next     = '0;
            current_chain_next    = 1'b1;
            repeats_left_next     = at_least_one(cfg.repeat_count);
            shift_word_next       = last_colour;
            in_low_phase_next     = 1'b0;
            phase_ticks_left_next = high_ticks(last_colour[COLOR_W-1], cfg);
          end else begin
            // frame done
            bit_position_next     = '0;
            repeats_left_next     = repeats_dec;
            sending_next          = 1'b0;
            current_chain_next    = 1'b0;
            in_low_phase_next     = 1'b0;
            phase_ticks_left_next = '0;
            shift_word_next       = '0;
          end
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    res.busy_res = sending_next;
    res.pin_zero = sending_next && !in_low_phase_next && !current_chain_next;
    res.pin_one  = sending_next && !in_low_phase_next && current_chain_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHAIN_COUNT; i++) begin
        chain_colours[i] <= '0;
      end
      sending          <= 1'b0;
      current_chain    <= 1'b0;
      repeats_left     <= '0;
      bit_position     <= '0;
      in_low_phase     <= 1'b0;
      phase_ticks_left <= '0;
      shift_word       <= '0;
    end else if (fire) begin
      if (colour_we) begin
        chain_colours[item.channel_index] <= rgb_to_grb(item.color_rgb);
      end
      sending          <= sending_next;
      current_chain    <= current_chain_next;
      repeats_left     <= repeats_left_next;
      bit_position     <= bit_position_next;
      in_low_phase     <= in_low_phase_next;
      phase_ticks_left <= phase_ticks_left_next;
      shift_word       <= shift_word_next;
    end
  end

endmodule

@@ hdl/addressable_led_chain_sender.sv @@
// ----------------------------------------------------------------------------
// addressable_led_chain_sender
// Two-chain one-wire RGB LED driver with stream command input and APB setup.
// ----------------------------------------------------------------------------
// Every transaction on the slave stream is a command: set a chain colour,
// start a frame, or advance the waveform by one tick. Every command yields
// exactly one master transaction with both data line levels and the busy flag
// as they stand after that command. The block sustains one transaction per
// clock while the result receiver keeps up; a result passes through the input
// register, then the output register, loaded together with the state update.
// The only loop is the frame state register with combinational next state, so
// back-to-back ticks run at full rate. Set and push are dropped while a frame
// is being sent. Timing and repeat registers are read live when a phase or a
// chain starts and should be written while the stream is idle.
module addressable_led_chain_sender import alcs_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  // command stream
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [23:0]           s_tdata,   // [23:0] color_rgb
  input  logic [2:0]            s_tuser,   // [1:0] cmd, [2] channel_index
  // result stream
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [7:0]            m_tdata,   // [0] pin_zero, [1] pin_one, [2] busy_res
  // configuration
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  timing_cfg_t cfg;
  led_item_t   in_item;
  logic        in_valid;
  logic        advance;
  logic        s_accept;
  led_result_t res;
  led_result_t out_res;

  // command moves into the engine whenever the output register has room
  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;
  assign s_accept = s_tvalid && s_tready;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_accept) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      in_item.cmd           <= cmd_t'(s_tuser[1:0]);
      in_item.channel_index <= s_tuser[2];
      in_item.color_rgb     <= s_tdata[COLOR_W-1:0];
    end
  end

  alcs_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  alcs_engine u_engine (
    .clk  (clk),
    .rst  (rst),
    .fire (advance),
    .item (in_item),
    .cfg  (cfg),
    .res  (res)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= res;
    end
  end

  assign m_tdata = {5'b0, out_res};

  // only one chain line may be driven high at a time
  a_one_pin_high: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[0] && m_tdata[1]))
    else $error("both chain lines high");

  // a high line only during a frame
  a_high_needs_busy: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tdata[0] || m_tdata[1])) |-> m_tdata[2])
    else $error("line high while not busy");

  // a held command stays in the input register while the output is stalled
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !advance) |=> (in_valid && $stable(in_item)))
    else $error("input register lost a pending command");

  // the engine only steps when the output register can take the result
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |-> !advance)
    else $error("result register overwritten");

endmodule

@@ dv/led_level_checker.sv @@
// ----------------------------------------------------------------------------
// led_level_checker
// Watches the command, result and register ports of the LED chain sender,
// predicts the line levels and busy flag of every command and compares them.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module led_level_checker import alcs_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  input  logic                  s_tready,
  input  logic [23:0]           s_tdata,   // [23:0] color_rgb
  input  logic [2:0]            s_tuser,   // [1:0] cmd, [2] channel_index
  input  logic                  m_tvalid,
  input  logic                  m_tready,
  input  logic [7:0]            m_tdata,   // [0] pin_zero, [1] pin_one, [2] busy_res
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  input  logic                  pready,
  input  logic                  end_of_run,
  output int                    level_count,
  output int                    fail_count
);

  // register mirror
  logic [TICK_W-1:0] cfg_one_hi, cfg_one_lo, cfg_zero_hi, cfg_zero_lo, cfg_repeat;

  // frame state
  logic [COLOR_W-1:0] grb_store [CHAIN_COUNT];
  logic               sending;
  logic               chain_sel;
  logic               low_phase;
  logic [TICK_W-1:0]  reps_left;
  logic [TICK_W-1:0]  ticks_left;
  logic [4:0]         bit_idx;
  logic [COLOR_W-1:0] shifter;

  led_result_t expected_levels [$];
  int          errs;
  int          levels_seen;
  logic        leftover_checked;

  function automatic logic [TICK_W-1:0] floor_one(input logic [TICK_W-1:0] v);
    return (v == '0) ? 8'd1 : v;
  endfunction

  function automatic void open_high_phase();
    low_phase  = 1'b0;
    ticks_left = floor_one(shifter[COLOR_W-1] ? cfg_one_hi : cfg_zero_hi);
  endfunction

  function automatic void open_chain(input logic c);
    chain_sel = c;
    reps_left = floor_one(cfg_repeat);
    bit_idx   = '0;
    shifter   = grb_store[c];
    open_high_phase();
  endfunction

  // high phase ends into the low phase; low phase ends into the next bit,
  // the next LED word, the next chain or the end of the frame
  function automatic void finish_phase();
    if (!low_phase) begin
      low_phase  = 1'b1;
      ticks_left = floor_one(shifter[COLOR_W-1] ? cfg_one_lo : cfg_zero_lo);
    end else begin
      shifter = shifter << 1;
      bit_idx = bit_idx + 5'd1;
      if (bit_idx < BITS_PER_LED) begin
        open_high_phase();
      end else begin
        bit_idx   = '0;
        reps_left = reps_left - 8'd1;
        if (reps_left != '0) begin
          shifter = grb_store[chain_sel];
          open_high_phase();
        end else if (chain_sel == 1'b0 && CHAIN_COUNT > 1) begin
          open_chain(1'b1);
        end else begin
          sending    = 1'b0;
          chain_sel  = 1'b0;
          low_phase  = 1'b0;
          ticks_left = '0;
          shifter    = '0;
        end
      end
    end
  endfunction

  function automatic led_result_t predict_levels(input led_item_t it);
    led_result_t r;
    case (it.cmd)
      CMD_SET: begin
        if (!sending && int'(it.channel_index) < CHAIN_COUNT)
          grb_store[it.channel_index] = {it.color_rgb[15:8], it.color_rgb[23:16],
                                         it.color_rgb[7:0]};
      end
      CMD_PUSH: begin
        if (!sending) begin
          sending = 1'b1;
          open_chain(1'b0);
        end
      end
      CMD_TICK: begin
        if (sending) begin
          ticks_left = ticks_left - 8'd1;
          if (ticks_left == '0)
            finish_phase();
        end
      end
      default: ;
    endcase
    r.pin_zero = sending && !low_phase && chain_sel == 1'b0;
    r.pin_one  = sending && !low_phase && chain_sel == 1'b1;
    r.busy_res = sending;
    return r;
  endfunction

  always @(posedge clk) begin : watch
    led_item_t   item;
    led_result_t seen;
    led_result_t want;
    if (rst) begin
      cfg_one_hi  = ONE_HIGH_RESET;
      cfg_one_lo  = ONE_LOW_RESET;
      cfg_zero_hi = ZERO_HIGH_RESET;
      cfg_zero_lo = ZERO_LOW_RESET;
      cfg_repeat  = REPEAT_RESET;
      for (int c = 0; c < CHAIN_COUNT; c++)
        grb_store[c] = '0;
      sending          = 1'b0;
      chain_sel        = 1'b0;
      low_phase        = 1'b0;
      reps_left        = '0;
      ticks_left       = '0;
      bit_idx          = '0;
      shifter          = '0;
      errs             = 0;
      levels_seen      = 0;
      leftover_checked = 1'b0;
      expected_levels.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[4:2]))
          REG_ONE_HIGH:  cfg_one_hi  = pwdata[7:0];
          REG_ONE_LOW:   cfg_one_lo  = pwdata[7:0];
          REG_ZERO_HIGH: cfg_zero_hi = pwdata[7:0];
          REG_ZERO_LOW:  cfg_zero_lo = pwdata[7:0];
          REG_REPEAT:    cfg_repeat  = pwdata[7:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        item.cmd           = cmd_t'(s_tuser[1:0]);
        item.channel_index = s_tuser[2];
        item.color_rgb     = s_tdata;
        expected_levels.push_back(predict_levels(item));
      end
      if (m_tvalid && m_tready) begin
        seen = m_tdata[2:0];
        levels_seen++;
        if (expected_levels.size() == 0) begin
          $error("result transaction with nothing expected, m_tdata %h", m_tdata);
          errs++;
        end else begin
          want = expected_levels.pop_front();
          if (seen.pin_zero !== want.pin_zero) begin
            $error("pin_zero: expected %0b, actual %0b", want.pin_zero, seen.pin_zero);
            errs++;
          end
          if (seen.pin_one !== want.pin_one) begin
            $error("pin_one: expected %0b, actual %0b", want.pin_one, seen.pin_one);
            errs++;
          end
          if (seen.busy_res !== want.busy_res) begin
            $error("busy_res: expected %0b, actual %0b", want.busy_res, seen.busy_res);
            errs++;
          end
        end
      end
      if (end_of_run && !leftover_checked) begin
        leftover_checked = 1'b1;
        if (expected_levels.size() != 0) begin
          $error("%0d expected results never arrived", expected_levels.size());
          errs += expected_levels.size();
        end
      end
    end
    fail_count  <= errs;
    level_count <= levels_seen;
  end

endmodule

@@ dv/addressable_led_chain_sender_test.sv @@
// ----------------------------------------------------------------------------
// addressable_led_chain_sender_test
// Drives commands and register writes into the LED chain sender and lets the
// level checker compare every result transaction against its own prediction.
// Directed frames cover reset timing, a register write in the middle of a
// frame, zero counts, busy commands and the longest phase; random frames with
// random colours and short timings follow, with bursty command traffic and a
// stalling result receiver.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module addressable_led_chain_sender_test;
  import alcs_pkg::*;

  localparam int CYCLE_LIMIT = 100_000;
  localparam int DRAIN_TAIL  = 4;     // two pipeline stages plus margin
  localparam int ITEM_TARGET = 1150;

  logic                  clk      = 1'b0;
  logic                  rst      = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [23:0]           s_tdata  = '0;    // [23:0] color_rgb
  logic [2:0]            s_tuser  = '0;    // [1:0] cmd, [2] channel_index
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [7:0]            m_tdata;          // [0] pin_zero, [1] pin_one, [2] busy_res
  logic                  psel     = 1'b0;
  logic                  penable  = 1'b0;
  logic                  pwrite   = 1'b0;
  logic [APB_ADDR_W-1:0] paddr    = '0;
  logic [APB_DATA_W-1:0] pwdata   = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  end_of_run = 1'b0;

  int level_count;
  int fail_count;

  // stimulus bookkeeping
  int  items_sent   = 0;
  int  burst_left   = 0;
  bit  steady       = 1'b0;   // no sender gaps while set
  int  cycle_count  = 0;
  logic last_busy   = 1'b0;   // busy flag of the latest result transaction

  // register values and stored colours as the stimulus last set them,
  // used only to know how many ticks a frame needs
  logic [TICK_W-1:0]  tick_cfg [5] = '{ONE_HIGH_RESET, ONE_LOW_RESET, ZERO_HIGH_RESET,
                                       ZERO_LOW_RESET, REPEAT_RESET};
  logic [COLOR_W-1:0] chain_rgb [CHAIN_COUNT] = '{default: '0};

  // receiver stall pattern state
  int rx_left = 0;
  bit rx_flow = 1'b0;

  always #2 clk = ~clk;

  addressable_led_chain_sender dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  led_level_checker levels_check (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .pready      (pready),
    .end_of_run  (end_of_run),
    .level_count (level_count),
    .fail_count  (fail_count)
  );

  // receiver: alternating flow and stall stretches, now and then a long
  // stretch of full flow
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_flow = !rx_flow;
      if (rx_flow)
        rx_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 16);
      else
        rx_left = $urandom_range(1, 4);
    end
    rx_left--;
    m_tready <= rx_flow;
  end

  // busy flag as the last result transaction reported it
  always @(posedge clk) begin
    if (m_tvalid && m_tready)
      last_busy <= m_tdata[2];
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic int count_floor(input logic [TICK_W-1:0] v);
    return (v == '0) ? 1 : int'(v);
  endfunction

  // ticks from push to end of frame; the number of one bits does not depend
  // on the byte order, so the raw colour is enough
  function automatic int frame_length();
    int total;
    int ones;
    int per_led;
    total = 0;
    for (int c = 0; c < CHAIN_COUNT; c++) begin
      ones    = $countones(chain_rgb[c]);
      per_led = ones * (count_floor(tick_cfg[REG_ONE_HIGH]) +
                        count_floor(tick_cfg[REG_ONE_LOW])) +
                (BITS_PER_LED - ones) * (count_floor(tick_cfg[REG_ZERO_HIGH]) +
                                         count_floor(tick_cfg[REG_ZERO_LOW]));
      total  += per_led * count_floor(tick_cfg[REG_REPEAT]);
    end
    return total;
  endfunction

  // one command transaction; bursts of random length with random gaps in
  // between, junk on the data lines while valid is low
  task automatic send_cmd(input cmd_t c, input logic ch, input logic [23:0] rgb);
    int gap;
    if (!steady) begin
      if (burst_left == 0) begin
        gap = $urandom_range(1, 8);
        s_tvalid <= 1'b0;
        s_tdata  <= 24'($urandom);
        s_tuser  <= 3'($urandom);
        repeat (gap) @(posedge clk);
        burst_left = $urandom_range(1, 24);
      end
      burst_left--;
    end
    s_tvalid <= 1'b1;
    s_tdata  <= rgb;
    s_tuser  <= {ch, c};
    do @(posedge clk); while (!s_tready);
    items_sent++;
  endtask

  // colour set while the block is idle
  task automatic set_colour(input logic ch, input logic [23:0] rgb);
    send_cmd(CMD_SET, ch, rgb);
    chain_rgb[ch] = rgb;
  endtask

  // commands the block must drop while a frame is on its way
  task automatic send_busy_noise();
    case ($urandom_range(0, 2))
      0:       send_cmd(CMD_SET, 1'($urandom), 24'($urandom));
      1:       send_cmd(CMD_PUSH, 1'($urandom), 24'($urandom));
      default: send_cmd(CMD_NOP, 1'($urandom), 24'($urandom));
    endcase
  endtask

  // push plus exactly enough ticks to finish the frame, with busy noise
  // mixed in before the last tick
  task automatic run_frame(input int noise_pct);
    int n;
    n = frame_length();
    send_cmd(CMD_PUSH, 1'($urandom), 24'($urandom));
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < noise_pct)
        send_busy_noise();
      send_cmd(CMD_TICK, 1'($urandom), 24'($urandom));
    end
  endtask

  // setup cycle, then access cycle; the register takes the value at the
  // edge where the access is ready
  task automatic write_reg(input reg_idx_t idx, input logic [7:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {24'h0, v};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    tick_cfg[idx] = v;
  endtask

  task automatic write_timing(input logic [7:0] oh, input logic [7:0] ol,
                              input logic [7:0] zh, input logic [7:0] zl,
                              input logic [7:0] rep);
    write_reg(REG_ONE_HIGH, oh);
    write_reg(REG_ONE_LOW, ol);
    write_reg(REG_ZERO_HIGH, zh);
    write_reg(REG_ZERO_LOW, zl);
    write_reg(REG_REPEAT, rep);
  endtask

  // stop sending and wait until every result transaction is back, then let
  // the pipeline settle
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (level_count != items_sent) @(posedge clk);
    repeat (DRAIN_TAIL) @(posedge clk);
  endtask

  // ticks in small groups until a result shows the frame has ended; the
  // few extra ticks land on an idle block
  task automatic tick_until_idle();
    wait_idle();
    while (last_busy) begin
      for (int i = 0; i < 8; i++)
        send_cmd(CMD_TICK, 1'b0, 24'h0);
      wait_idle();
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // idle behavior at reset: tick and unknown command change nothing,
    // colour extremes on both chains
    send_cmd(CMD_TICK, 1'b1, 24'hFFFFFF);
    send_cmd(CMD_NOP, 1'b0, 24'h000000);
    set_colour(1'b0, 24'hFFFFFF);
    set_colour(1'b1, 24'h000000);
    set_colour(1'b1, 24'hC3A55A);
    set_colour(1'b0, 24'h0080A5);

    // first two bits at reset timing, a one then a zero, no sender gaps
    steady = 1'b1;
    send_cmd(CMD_PUSH, 1'b0, 24'h0);
    for (int i = 0; i < 50; i++)
      send_cmd(CMD_TICK, 1'b0, 24'h0);
    steady = 1'b0;

    // shorter phases from the next phase on, second chain with one LED
    wait_idle();
    write_timing(8'd1, 8'd1, 8'd1, 8'd1, 8'd1);
    tick_until_idle();

    // zero counts behave as one, busy set, push and unknown commands dropped
    wait_idle();
    write_timing(8'd1, 8'd2, 8'd0, 8'd3, 8'd0);
    set_colour(1'b0, 24'hF0F0F0);
    set_colour(1'b1, 24'h0F0F0F);
    run_frame(30);
    send_cmd(CMD_NOP, 1'b1, 24'h0);
    send_cmd(CMD_TICK, 1'b0, 24'h0);

    // longest high phase of a one bit
    wait_idle();
    write_timing(8'd255, 8'd0, 8'd0, 8'd1, 8'd1);
    set_colour(1'b0, 24'h000100);
    set_colour(1'b1, 24'h000000);
    steady = 1'b1;
    run_frame(0);
    steady = 1'b0;

    // short timings before the random frames
    wait_idle();
    write_timing(8'd2, 8'd1, 8'd1, 8'd2, 8'd1);

    // random frames: short timings, random colours, busy noise; most frames
    // after a full drain and a new register setting, some back to back
    while (items_sent < ITEM_TARGET) begin
      if ($urandom_range(0, 2) != 0) begin
        wait_idle();
        for (int r = 0; r < 5; r++) begin
          if ($urandom_range(0, 1) == 1) begin
            if (r == int'(REG_REPEAT))
              write_reg(reg_idx_t'(r), 8'($urandom_range(0, 2)));
            else if ($urandom_range(0, 7) == 0)
              write_reg(reg_idx_t'(r), 8'($urandom_range(4, 9)));
            else
              write_reg(reg_idx_t'(r), 8'($urandom_range(0, 3)));
          end
        end
      end
      // idle tick or unknown command between frames
      if ($urandom_range(0, 3) == 0)
        send_cmd(($urandom_range(0, 1) == 1) ? CMD_TICK : CMD_NOP, 1'($urandom),
                 24'($urandom));
      // new colours, sometimes an extreme, sometimes kept
      for (int c = 0; c < CHAIN_COUNT; c++) begin
        case ($urandom_range(0, 5))
          0:       set_colour(c[0], 24'h000000);
          1:       set_colour(c[0], 24'hFFFFFF);
          2:       ;
          default: set_colour(c[0], 24'($urandom));
        endcase
      end
      run_frame($urandom_range(0, 15));
    end

    // drain and verdict
    wait_idle();
    end_of_run <= 1'b1;
    repeat (3) @(posedge clk);
    if (fail_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

@@ files.f @@
hdl/alcs_pkg.sv
hdl/alcs_cfg_regs.sv
hdl/alcs_engine.sv
hdl/addressable_led_chain_sender.sv
dv/led_level_checker.sv
dv/addressable_led_chain_sender_test.sv
